// File: design/assert_macros.svh
// Assertion macros for the RTL of the fixed-point to radix text converter.
// No dependencies; included by the files that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication, checked at every rising edge outside reset.
`define FXRT_ASSERT_IMP(label, ck, rstn, ante, cons) \
	label: assert property (@(posedge ck) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("fxrt assertion failed");
// Next-cycle implication, checked at every rising edge outside reset.
`define FXRT_ASSERT_NXT(label, ck, rstn, ante, cons) \
	label: assert property (@(posedge ck) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("fxrt assertion failed");
`else
`define FXRT_ASSERT_IMP(label, ck, rstn, ante, cons)
`define FXRT_ASSERT_NXT(label, ck, rstn, ante, cons)
`endif
`endif

// File: design/fxrt_pkg.sv
// Package for the fixed-point to radix text converter: types, character codes, glyph lookup.
// No dependencies; used by the controller, the datapath and the top level.
`timescale 1ns / 1ps
`default_nettype none
package fxrt_pkg;

	// Radix register width, legal range and default.
	localparam int RADIX_W = 6;
	localparam logic [RADIX_W-1:0] RADIX_DEFAULT = 6'd10;
	localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;
	localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd36;
	localparam logic [RADIX_W-1:0] RADIX_SW_DEFAULT = 6'd0;

	// ASCII codes used in the text.
	localparam logic [7:0] CHAR_ZERO = 8'h30;
	localparam logic [7:0] CHAR_LOWER_A = 8'h61;
	localparam logic [7:0] CHAR_POINT = 8'h2e;
	localparam logic [7:0] CHAR_MINUS = 8'h2d;
	localparam logic [7:0] DECIMAL_DIGITS = 8'd10;

	// Controller states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_DIV,
		ST_STORE,
		ST_SIGN,
		ST_INT,
		ST_POINT,
		ST_FRAC
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic store_zero;
		logic div_init;
		logic div_step;
		logic store_digit;
		logic emit_sign;
		logic emit_int;
		logic emit_point;
		logic emit_frac;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic neg;
		logic quo_zero;
		logic count_zero;
		logic count_full;
		logic bit_last;
		logic idx_zero;
		logic frac_last;
		logic out_free;
	} status_t;

	// Maps a digit value to its lower-case ASCII glyph.
	function automatic logic [7:0] glyph(input logic [RADIX_W-1:0] d);
		logic [7:0] wide;
		wide = {2'b00, d};
		if (wide < DECIMAL_DIGITS) begin
			return CHAR_ZERO + wide;
		end else begin
			return CHAR_LOWER_A + (wide - DECIMAL_DIGITS);
		end
	endfunction

endpackage
`default_nettype wire

// File: design/fxrt_ctrl.sv
// Controller state machine of the fixed-point to radix text converter.
// Depends on fxrt_pkg; drives datapath commands from datapath status.
`timescale 1ns / 1ps
`default_nettype none
module fxrt_ctrl
	import fxrt_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    in_valid,
	input  wire status_t status,
	output cmd_t         cmd,
	output logic         idle
);

	state_t state_q;
	state_t state_next;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	// Next state and commands.
	always_comb begin
		state_next = state_q;
		cmd = '0;
		idle = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				idle = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_next = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (status.quo_zero) begin
					cmd.store_zero = status.count_zero;
					state_next = ST_SIGN;
				end else if (status.count_full) begin
					state_next = ST_SIGN;
				end else begin
					cmd.div_init = 1'b1;
					state_next = ST_DIV;
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (status.bit_last) begin
					state_next = ST_STORE;
				end
			end
			ST_STORE: begin
				cmd.store_digit = 1'b1;
				state_next = ST_CHECK;
			end
			ST_SIGN: begin
				if (!status.neg) begin
					state_next = ST_INT;
				end else if (status.out_free) begin
					cmd.emit_sign = 1'b1;
					state_next = ST_INT;
				end
			end
			ST_INT: begin
				if (status.out_free) begin
					cmd.emit_int = 1'b1;
					if (status.idx_zero) begin
						state_next = ST_POINT;
					end
				end
			end
			ST_POINT: begin
				if (status.out_free) begin
					cmd.emit_point = 1'b1;
					state_next = ST_FRAC;
				end
			end
			ST_FRAC: begin
				if (status.out_free) begin
					cmd.emit_frac = 1'b1;
					if (status.frac_last) begin
						state_next = ST_IDLE;
					end
				end
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

// File: design/fxrt_dp.sv
// Datapath of the fixed-point to radix text converter: radix register, bit-serial divider,
// digit store, fraction multiplier and output register. Depends on fxrt_pkg.
`timescale 1ns / 1ps
`default_nettype none
module fxrt_dp
	import fxrt_pkg::*;
#(
	parameter int INT_BITS    = 31,
	parameter int FRAC_BITS   = 16,
	parameter int FRAC_DIGITS = 4
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_we,
	input  wire logic [RADIX_W-1:0]               cfg_radix,
	input  wire logic signed [INT_BITS+FRAC_BITS:0] fixed_value,
	input  wire logic                             out_stall,
	input  wire cmd_t                             cmd,
	output status_t                               status,
	output logic                                  out_valid,
	output logic [7:0]                            text_char,
	output logic                                  last_char
);

	localparam int VB  = INT_BITS + FRAC_BITS + 1;
	localparam int CW  = $clog2(INT_BITS + 1);
	localparam int IW  = $clog2(INT_BITS);
	localparam int FCW = (FRAC_DIGITS > 1) ? $clog2(FRAC_DIGITS) : 1;
	localparam int PW  = FRAC_BITS + RADIX_W;

	logic [RADIX_W-1:0]   radix_q;
	logic                 neg_q;
	logic [INT_BITS-1:0]  quo_q;
	logic [RADIX_W-1:0]   rem_q;
	logic [FRAC_BITS-1:0] frac_q;
	logic [IW-1:0]        bit_cnt_q;
	logic [CW-1:0]        count_q;
	logic [IW-1:0]        emit_idx_q;
	logic [FCW-1:0]       frac_cnt_q;
	logic [RADIX_W-1:0]   store_q [INT_BITS];
	logic                 out_valid_q;
	logic [7:0]           char_q;
	logic                 last_q;

	logic [VB-1:0]        raw_v;
	logic [VB-1:0]        abs_v;
	logic [VB-1:0]        sat_v;
	logic [RADIX_W:0]     partial;
	logic                 ge;
	logic [RADIX_W:0]     rem_diff;
	logic [PW-1:0]        prod;
	logic [RADIX_W-1:0]   frac_digit;
	logic                 out_free;

	// Magnitude of the input, saturated for the most negative value.
	always_comb begin
		raw_v = $unsigned(fixed_value);
		abs_v = raw_v[VB-1] ? (~raw_v + 1'b1) : raw_v;
		sat_v = abs_v[VB-1] ? {1'b0, {(VB-1){1'b1}}} : abs_v;
	end

	// One restoring division step: shift in the next dividend bit, subtract if it fits.
	always_comb begin
		partial = {rem_q, quo_q[INT_BITS-1]};
		ge = partial >= {1'b0, radix_q};
		rem_diff = partial - {1'b0, radix_q};
	end

	// Next fraction digit by multiplication with the radix.
	always_comb begin
		prod = PW'(frac_q) * PW'(radix_q);
		frac_digit = prod[PW-1:FRAC_BITS];
	end

	assign out_free = !out_valid_q || !out_stall;

	// Radix register; zero selects the default and out-of-range writes are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q <= RADIX_DEFAULT;
		end else if (cfg_we) begin
			if (cfg_radix == RADIX_SW_DEFAULT) begin
				radix_q <= RADIX_DEFAULT;
			end else if (cfg_radix >= RADIX_MIN && cfg_radix <= RADIX_MAX) begin
				radix_q <= cfg_radix;
			end
		end
	end

	// Counters and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			bit_cnt_q   <= '0;
			emit_idx_q  <= '0;
			frac_cnt_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				count_q    <= '0;
				frac_cnt_q <= '0;
			end
			if (cmd.store_zero) begin
				count_q    <= CW'(1);
				emit_idx_q <= '0;
			end
			if (cmd.div_init) begin
				bit_cnt_q <= '0;
			end
			if (cmd.div_step) begin
				bit_cnt_q <= bit_cnt_q + 1'b1;
			end
			if (cmd.store_digit) begin
				count_q    <= count_q + 1'b1;
				emit_idx_q <= count_q[IW-1:0];
			end
			if (cmd.emit_int) begin
				emit_idx_q <= emit_idx_q - 1'b1;
			end
			if (cmd.emit_frac) begin
				frac_cnt_q <= frac_cnt_q + 1'b1;
			end
			if (cmd.emit_sign || cmd.emit_int || cmd.emit_point || cmd.emit_frac) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Working values, digit store and output character.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			neg_q  <= raw_v[VB-1];
			quo_q  <= sat_v[VB-2:FRAC_BITS];
			frac_q <= sat_v[FRAC_BITS-1:0];
		end
		if (cmd.store_zero) begin
			store_q[0] <= '0;
		end
		if (cmd.div_init) begin
			rem_q <= '0;
		end
		if (cmd.div_step) begin
			quo_q <= {quo_q[INT_BITS-2:0], ge};
			rem_q <= ge ? rem_diff[RADIX_W-1:0] : partial[RADIX_W-1:0];
		end
		if (cmd.store_digit) begin
			store_q[count_q[IW-1:0]] <= rem_q;
		end
		if (cmd.emit_sign) begin
			char_q <= CHAR_MINUS;
			last_q <= 1'b0;
		end
		if (cmd.emit_int) begin
			char_q <= glyph(store_q[emit_idx_q]);
			last_q <= 1'b0;
		end
		if (cmd.emit_point) begin
			char_q <= CHAR_POINT;
			last_q <= 1'b0;
		end
		if (cmd.emit_frac) begin
			char_q <= glyph(frac_digit);
			last_q <= (frac_cnt_q == FCW'(FRAC_DIGITS - 1));
			frac_q <= prod[FRAC_BITS-1:0];
		end
	end

	// Status back to the controller.
	always_comb begin
		status.neg        = neg_q;
		status.quo_zero   = (quo_q == '0);
		status.count_zero = (count_q == '0);
		status.count_full = (count_q == CW'(INT_BITS));
		status.bit_last   = (bit_cnt_q == IW'(INT_BITS - 1));
		status.idx_zero   = (emit_idx_q == '0);
		status.frac_last  = (frac_cnt_q == FCW'(FRAC_DIGITS - 1));
		status.out_free   = out_free;
	end

	assign out_valid = out_valid_q;
	assign text_char = char_q;
	assign last_char = last_q;

endmodule
`default_nettype wire

// File: design/fixed_to_radix_text_top.sv
// Top level of the fixed-point to radix text converter.
// Depends on fxrt_pkg, fxrt_ctrl, fxrt_dp and assert_macros.svh.
//
//   channel   signals                        direction  meaning
//   in        in_valid, in_stall, fixed_value   in         one signed fixed-point value
//   out       out_valid, out_stall, text_char,  out        one character of its text
//             last_char
//   cfg       cfg_valid, cfg_ready, radix       in         radix register write
//
// Each integer digit passes through the check, the steps of the one-bit-per-cycle divider and
// the store. Once the digits are stored, each character leaves through the output register,
// one per cycle without stalls.
// Reset sets the radix to ten and the block idle; the digit store is not cleared.
// An output stall holds the current character and pauses emission of the next one.
// A new item is taken once the last character sits in the output register.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module fixed_to_radix_text_top
	import fxrt_pkg::*;
#(
	parameter int INT_BITS    = 31,
	parameter int FRAC_BITS   = 16,
	parameter int FRAC_DIGITS = 4
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               in_valid,
	output logic                                    in_stall,
	input  wire logic signed [INT_BITS+FRAC_BITS:0] fixed_value,
	output logic                                    out_valid,
	input  wire logic                               out_stall,
	output logic [7:0]                              text_char,
	output logic                                    last_char,
	input  wire logic                               cfg_valid,
	output logic                                    cfg_ready,
	input  wire logic [RADIX_W-1:0]                 radix
);

	cmd_t    cmd;
	status_t status;
	logic    idle;
	logic    cfg_we;
	logic [3:0] emit_vec;

	// Handshake glue: items and register writes are taken while the controller is idle.
	assign in_stall  = !idle;
	assign cfg_ready = idle;
	assign cfg_we    = cfg_valid && cfg_ready;
	assign emit_vec  = {cmd.emit_sign, cmd.emit_int, cmd.emit_point, cmd.emit_frac};

	// Controller.
	fxrt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.status   (status),
		.cmd      (cmd),
		.idle     (idle)
	);

	// Datapath.
	fxrt_dp #(
		.INT_BITS    (INT_BITS),
		.FRAC_BITS   (FRAC_BITS),
		.FRAC_DIGITS (FRAC_DIGITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_radix   (radix),
		.fixed_value (fixed_value),
		.out_stall   (out_stall),
		.cmd         (cmd),
		.status      (status),
		.out_valid   (out_valid),
		.text_char   (text_char),
		.last_char   (last_char)
	);

	// At most one character is produced per cycle.
	`FXRT_ASSERT_IMP(a_one_emit, clk, arst_n, 1'b1, $onehot0(emit_vec))
	// A character is only produced when the output register can take it.
	`FXRT_ASSERT_IMP(a_emit_room, clk, arst_n, emit_vec != 4'b0000, status.out_free)
	// An accepted item keeps the input stalled in the following cycle.
	`FXRT_ASSERT_NXT(a_busy_after_accept, clk, arst_n, in_valid && !in_stall, in_stall)

endmodule
`default_nettype wire

// File: dv/fixed_to_radix_text_top_test.sv
// Self-checking test of fixed_to_radix_text_top: fixed-point values go in, their text in the
// current radix is predicted here and compared character by character. Depends on fxrt_pkg
// and the RTL of the converter.
`timescale 1ns / 1ps
module fixed_to_radix_text_top_test
	import fxrt_pkg::*;
();

	localparam int VALUE_W = 48;
	localparam int INT_DIGITS_MAX = 31;
	localparam int FRAC_DIGITS = 4;
	localparam logic [VALUE_W-1:0] MAX_MAG = 48'h7FFF_FFFF_FFFF;
	localparam logic [VALUE_W-1:0] MOST_NEG = 48'h8000_0000_0000;
	localparam int QUIET_LIMIT = 20000;
	localparam int HOLDOFF_CYCLES = 400;
	localparam int SETTLE_CYCLES = 8;

	// One expected character of the text.
	typedef struct packed {
		logic [7:0] ch;
		logic       last;
	} text_item_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [VALUE_W-1:0] fixed_value = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [7:0] text_char;
	logic last_char;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [RADIX_W-1:0] radix = '0;

	text_item_t pending_text[$];
	text_item_t oldest_text;
	logic [RADIX_W-1:0] base_now = RADIX_DEFAULT;
	int fail_count = 0;
	int quiet_cycles = 0;
	bit tx_idling = 1'b1;
	bit rx_idling = 1'b1;
	int holdoff_request = 0;
	int hold_left = 0;
	int run_left = 0;
	bit stall_run = 1'b0;

	fixed_to_radix_text_top DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.fixed_value(fixed_value),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.text_char(text_char),
		.last_char(last_char),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.radix(radix)
	);

	// Free-running clock with a 2 ns period.
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Idle stretch length: mostly short, now and then long.
	function automatic int idle_length();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 70) begin
			return $urandom_range(1, 3);
		end else if (pick < 95) begin
			return $urandom_range(4, 12);
		end
		return $urandom_range(20, 60);
	endfunction

	// ASCII glyph of one digit value.
	function automatic logic [7:0] digit_char(input logic [5:0] d);
		if (d < 6'd10) begin
			return CHAR_ZERO + {2'b00, d};
		end
		return CHAR_LOWER_A + {2'b00, d} - 8'd10;
	endfunction

	function automatic void add_char(input logic [7:0] c, input logic last);
		text_item_t item;
		item.ch = c;
		item.last = last;
		pending_text.push_back(item);
	endfunction

	// Expected text of one value: sign, integer digits, point, truncated fraction digits.
	function automatic void predict_text(input logic [VALUE_W-1:0] value,
			input logic [RADIX_W-1:0] base);
		logic [VALUE_W-1:0] mag;
		logic [30:0] int_left;
		logic [15:0] frac_left;
		logic [21:0] prod;
		logic [5:0] digits [0:INT_DIGITS_MAX-1];
		int count;
		int k;
		mag = value[VALUE_W-1] ? (~value + 48'd1) : value;
		// The most negative value has no positive twin, so its magnitude saturates.
		if (mag > MAX_MAG) begin
			mag = MAX_MAG;
		end
		int_left = mag[46:16];
		frac_left = mag[15:0];
		count = 0;
		if (int_left == 0) begin
			digits[0] = 6'd0;
			count = 1;
		end
		while (int_left != 0 && count < INT_DIGITS_MAX) begin
			digits[count] = 6'(int_left % base);
			int_left = int_left / base;
			count++;
		end
		// The sign shows even when the integer part is zero.
		if (value[VALUE_W-1]) begin
			add_char(CHAR_MINUS, 1'b0);
		end
		for (k = count - 1; k >= 0; k--) begin
			add_char(digit_char(digits[k]), 1'b0);
		end
		add_char(CHAR_POINT, 1'b0);
		for (k = 0; k < FRAC_DIGITS; k++) begin
			prod = frac_left * base;
			add_char(digit_char(prod[21:16]), k == FRAC_DIGITS - 1);
			frac_left = prod[15:0];
		end
	endfunction

	// Random value drawn from several magnitude classes, with a random sign.
	function automatic logic [VALUE_W-1:0] random_value();
		logic [63:0] full;
		logic [VALUE_W-1:0] mag;
		full = {$urandom, $urandom};
		mag = '0;
		case ($urandom_range(0, 5))
			0: begin
				return full[VALUE_W-1:0];
			end
			1: begin
				mag = (48'($urandom_range(0, 1000)) << 16) | 48'($urandom_range(0, 65535));
			end
			2: begin
				mag = 48'($urandom_range(0, 65535));
			end
			3: begin
				mag = {1'b0, full[46:0]} >> $urandom_range(0, 46);
			end
			4: begin
				mag = 48'($urandom_range(1, 50000)) << 16;
			end
			default: begin
				case ($urandom_range(0, 4))
					0: mag = MAX_MAG;
					1: mag = 48'd1;
					2: mag = 48'hFFFF;
					3: mag = 48'h10000;
					default: return MOST_NEG;
				endcase
			end
		endcase
		return $urandom_range(0, 1) ? (~mag + 48'd1) : mag;
	endfunction

	// Offers one value, waits until it is taken and records its expected text.
	task automatic send_value(input logic [VALUE_W-1:0] value);
		int gap;
		gap = (tx_idling && $urandom_range(0, 1)) ? idle_length() : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		fixed_value <= value;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		predict_text(value, base_now);
	endtask

	// Stops offering items and waits until every expected character has come.
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_text.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Writes the radix register; zero selects ten and out-of-range codes are dropped.
	task automatic write_radix(input logic [RADIX_W-1:0] value);
		cfg_valid <= 1'b1;
		radix <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		if (value == RADIX_SW_DEFAULT) begin
			base_now = RADIX_DEFAULT;
		end else if (value >= RADIX_MIN && value <= RADIX_MAX) begin
			base_now = value;
		end
	endtask

	// Decimal text after reset: zero, extremes, sign cases and fraction edges.
	task automatic test_default_radix();
		send_value(48'd0);
		send_value(48'h10000);
		send_value(-48'sh8000);
		send_value(MAX_MAG);
		send_value(MOST_NEG);
		send_value(~MAX_MAG + 48'd1);
		send_value(48'd1);
		send_value(-48'sh10000);
		send_value(48'hFFFF);
		wait_idle();
	endtask

	// Smallest and largest radix, the default code and codes that must be ignored.
	task automatic test_radix_settings();
		write_radix(6'd2);
		send_value(MAX_MAG);
		send_value(MOST_NEG);
		send_value(48'h5555_5555_5555);
		wait_idle();
		write_radix(RADIX_MAX);
		send_value(MAX_MAG);
		send_value(48'd35 << 16);
		send_value(-48'sh1234_5678);
		wait_idle();
		write_radix(RADIX_SW_DEFAULT);
		send_value(48'd123 << 16 | 48'h74BC);
		wait_idle();
		write_radix(6'd1);
		send_value(48'h7B_0000);
		wait_idle();
		write_radix(6'd63);
		send_value(-48'sh7B_8000);
		wait_idle();
		write_radix(6'd37);
		send_value(48'hFFFF_FFFF);
		wait_idle();
		write_radix(6'd16);
		send_value(48'hDEAD_BEEF);
		send_value(-48'sh1);
		wait_idle();
	endtask

	// The receiver holds off long enough that the block backs up onto its input.
	task automatic test_output_holdoff();
		int k;
		write_radix(6'd10);
		tx_idling = 1'b0;
		holdoff_request = HOLDOFF_CYCLES;
		for (k = 0; k < 8; k++) begin
			send_value(random_value());
		end
		tx_idling = 1'b1;
		wait_idle();
	endtask

	// The sender pauses until all text has drained, then resumes.
	task automatic test_drain_pause();
		int k;
		for (k = 0; k < 6; k++) begin
			send_value(random_value());
		end
		wait_idle();
		for (k = 0; k < 6; k++) begin
			send_value(random_value());
		end
		wait_idle();
	endtask

	// Random phases, each with its own radix code and idling pattern.
	task automatic test_random_values(input int phases);
		int p;
		int k;
		logic [RADIX_W-1:0] code;
		for (p = 0; p < phases; p++) begin
			code = ($urandom_range(0, 3) != 0) ? 6'($urandom_range(2, 36))
				: 6'($urandom_range(0, 63));
			write_radix(code);
			tx_idling = ($urandom_range(0, 3) != 0);
			rx_idling = ($urandom_range(0, 3) != 0);
			for (k = 0; k < 24; k++) begin
				send_value(random_value());
			end
			wait_idle();
		end
		tx_idling = 1'b1;
		rx_idling = 1'b1;
	endtask

	// Output stall: a requested long hold-off first, otherwise random runs while the receiver idles.
	always @(posedge clk) begin
		if (holdoff_request > 0) begin
			hold_left = holdoff_request;
			holdoff_request = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else if (!rx_idling) begin
			out_stall <= 1'b0;
		end else begin
			if (run_left == 0) begin
				stall_run = ($urandom_range(0, 3) == 0);
				run_left = stall_run ? idle_length() : $urandom_range(1, 10);
			end
			run_left--;
			out_stall <= stall_run;
		end
	end

	// Each accepted character is compared with the oldest expected one.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_text.size() == 0) begin
				if (fail_count < 10) begin
					$display("unexpected character %h last %b", text_char, last_char);
				end
				fail_count++;
			end else begin
				oldest_text = pending_text.pop_front();
				if (oldest_text.ch !== text_char || oldest_text.last !== last_char) begin
					if (fail_count < 10) begin
						$display("text mismatch: expected char %h last %b, got char %h last %b",
							oldest_text.ch, oldest_text.last, text_char, last_char);
					end
					fail_count++;
				end
			end
		end
	end

	// Watchdog on cycles in which no channel moves an item.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
				|| (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("timeout after %0d quiet cycles", quiet_cycles);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// Reset, then the tests in turn, then the verdict.
	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_default_radix();
		test_radix_settings();
		test_output_holdoff();
		test_drain_pause();
		test_random_values(9);
		wait_idle();
		repeat (40) @(posedge clk);
		if (fail_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

// File: files.f
+incdir+design
design/fxrt_pkg.sv
design/fxrt_ctrl.sv
design/fxrt_dp.sv
design/fixed_to_radix_text_top.sv
dv/fixed_to_radix_text_top_test.sv
